@@ sv/sirrk4_pkg.sv @@
`timescale 1ns / 1ps
package sirrk4_pkg;

    localparam int CW = 41;
    localparam int TW = 32;
    localparam int RW = 16;
    localparam int NW = 21;
    localparam int QW = CW + 3;
    localparam int AW = 56;
    localparam int BW = 50;
    localparam int PW = AW + BW;
    localparam int SW = PW + 2;
    localparam int OPW = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DEF_VALUE_FRAC_BITS = 20;

    localparam int RCP3_SH = 51;
    localparam logic [BW-1:0] RCP3 = 50'd750599937895083;

    localparam logic [CFG_IDX_W-1:0] REG_INFECTION_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_RATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_POPULATION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_TIME = 3'd4;

    localparam logic [RW-1:0] RST_INFECTION_RATE = 16'd3277;
    localparam logic [RW-1:0] RST_RECOVERY_RATE = 16'd655;
    localparam logic [NW-1:0] RST_TOTAL_POPULATION = 21'd1000;
    localparam logic [RW-1:0] RST_STEP_SIZE = 16'd1280;
    localparam logic [TW-1:0] RST_STOP_TIME = 32'd128000;

    localparam logic [OPW-1:0] OP_LOAD = 4'd0;
    localparam logic [OPW-1:0] OP_HOLD = 4'd1;
    localparam logic [OPW-1:0] OP_MUL_AI = 4'd2;
    localparam logic [OPW-1:0] OP_MUL_AS = 4'd3;
    localparam logic [OPW-1:0] OP_DIV_N = 4'd4;
    localparam logic [OPW-1:0] OP_MUL_GI = 4'd5;
    localparam logic [OPW-1:0] OP_DERIV = 4'd6;
    localparam logic [OPW-1:0] OP_MUL_KH = 4'd7;
    localparam logic [OPW-1:0] OP_MUL_LH = 4'd8;
    localparam logic [OPW-1:0] OP_MUL_FK = 4'd9;
    localparam logic [OPW-1:0] OP_DIV_FK = 4'd10;
    localparam logic [OPW-1:0] OP_MUL_FL = 4'd11;
    localparam logic [OPW-1:0] OP_DIV_FL = 4'd12;
    localparam logic [OPW-1:0] OP_MUL_FM = 4'd13;
    localparam logic [OPW-1:0] OP_DIV_FM = 4'd14;
    localparam logic [OPW-1:0] OP_TIME = 4'd15;

    typedef logic signed [CW-1:0] t_cnt;
    typedef logic signed [QW-1:0] t_acc;
    typedef logic signed [SW-1:0] t_wide;

    typedef struct packed {
        t_cnt v;
        logic sat;
    } t_clip;

    typedef struct packed {
        logic            accept;
        logic            start;
        logic [OPW-1:0]  op;
        logic [1:0]      stage;
        logic            publish;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic at_stop;
        logic out_free;
    } t_sts;

    function automatic t_clip sat_cnt(input t_wide v);
        t_clip c;
        if ((&v[SW-1:CW-1]) || !(|v[SW-1:CW-1])) begin
            c.v = v[CW-1:0];
            c.sat = 1'b0;
        end else begin
            c.sat = 1'b1;
            c.v = v[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        return c;
    endfunction

endpackage

@@ sv/sirrk4_ctrl.sv @@
`timescale 1ns / 1ps
module sirrk4_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_cmd,
    input  sirrk4_pkg::t_sts  i_sts,
    output sirrk4_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;

    logic [1:0] r_state, n_state;
    logic [sirrk4_pkg::OPW-1:0] r_op, n_op;
    logic [1:0] r_stage, n_stage;
    logic r_start, n_start;
    logic w_accept;

    assign w_accept = i_valid && (r_state == ST_IDLE);
    assign o_stall = (r_state != ST_IDLE);

    assign o_cmd.accept = w_accept;
    assign o_cmd.start = r_start;
    assign o_cmd.op = r_op;
    assign o_cmd.stage = r_stage;
    assign o_cmd.publish = (r_state == ST_OUT) && i_sts.out_free;

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_stage = r_stage;
        n_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_BUSY;
                    n_stage = 2'd0;
                    n_start = 1'b1;
                    if (!i_cmd) begin
                        n_op = sirrk4_pkg::OP_LOAD;
                    end else if (i_sts.at_stop) begin
                        n_op = sirrk4_pkg::OP_HOLD;
                    end else begin
                        n_op = sirrk4_pkg::OP_MUL_AI;
                    end
                end
            end
            ST_BUSY: begin
                if (i_sts.done) begin
                    n_start = 1'b1;
                    case (r_op)
                        sirrk4_pkg::OP_MUL_AI: n_op = sirrk4_pkg::OP_MUL_AS;
                        sirrk4_pkg::OP_MUL_AS: n_op = sirrk4_pkg::OP_DIV_N;
                        sirrk4_pkg::OP_DIV_N:  n_op = sirrk4_pkg::OP_MUL_GI;
                        sirrk4_pkg::OP_MUL_GI: n_op = sirrk4_pkg::OP_DERIV;
                        sirrk4_pkg::OP_DERIV: begin
                            n_op = (r_stage == 2'd3) ? sirrk4_pkg::OP_MUL_FK
                                                     : sirrk4_pkg::OP_MUL_KH;
                        end
                        sirrk4_pkg::OP_MUL_KH: n_op = sirrk4_pkg::OP_MUL_LH;
                        sirrk4_pkg::OP_MUL_LH: begin
                            n_op = sirrk4_pkg::OP_MUL_AI;
                            n_stage = r_stage + 2'd1;
                        end
                        sirrk4_pkg::OP_MUL_FK: n_op = sirrk4_pkg::OP_DIV_FK;
                        sirrk4_pkg::OP_DIV_FK: n_op = sirrk4_pkg::OP_MUL_FL;
                        sirrk4_pkg::OP_MUL_FL: n_op = sirrk4_pkg::OP_DIV_FL;
                        sirrk4_pkg::OP_DIV_FL: n_op = sirrk4_pkg::OP_MUL_FM;
                        sirrk4_pkg::OP_MUL_FM: n_op = sirrk4_pkg::OP_DIV_FM;
                        sirrk4_pkg::OP_DIV_FM: n_op = sirrk4_pkg::OP_TIME;
                        default: begin
                            n_start = 1'b0;
                            n_state = ST_OUT;
                        end
                    endcase
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op <= sirrk4_pkg::OP_LOAD;
            r_stage <= 2'd0;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op <= n_op;
            r_stage <= n_stage;
            r_start <= n_start;
        end
    end

endmodule

@@ sv/sirrk4_dp.sv @@
`timescale 1ns / 1ps
module sirrk4_dp #(
    parameter int P_VALUE_FRAC_BITS = sirrk4_pkg::DEF_VALUE_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [sirrk4_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sirrk4_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  sirrk4_pkg::t_cnt                    i_load_susceptible,
    input  sirrk4_pkg::t_cnt                    i_load_infected,
    input  sirrk4_pkg::t_cnt                    i_load_recovered,
    input  sirrk4_pkg::t_cmd                    i_cmd,
    output sirrk4_pkg::t_sts                    o_sts,
    input  logic                                i_stall,
    output logic                                o_valid,
    output sirrk4_pkg::t_cnt                    o_susceptible,
    output sirrk4_pkg::t_cnt                    o_infected,
    output sirrk4_pkg::t_cnt                    o_recovered,
    output logic [sirrk4_pkg::TW-1:0]           o_elapsed_time,
    output logic                                o_finished,
    output logic                                o_saturated
);

    localparam int CW = sirrk4_pkg::CW;
    localparam int PW = sirrk4_pkg::PW;
    localparam int BW = sirrk4_pkg::BW;
    localparam int AW = sirrk4_pkg::AW;
    localparam int QW = sirrk4_pkg::QW;
    localparam int NW = sirrk4_pkg::NW;
    localparam int TW = sirrk4_pkg::TW;
    localparam int RW = sirrk4_pkg::RW;
    localparam int SH = P_VALUE_FRAC_BITS + 16;
    localparam int XW = PW - SH;
    localparam int KW = $clog2(XW + 1);

    logic [RW-1:0] r_beta, r_gamma, r_h;
    logic [NW-1:0] r_pop;
    logic [TW-1:0] r_stop, r_time;
    sirrk4_pkg::t_cnt r_s, r_i, r_r, r_ss, r_ii, r_inf, r_rec, r_k, r_l;
    sirrk4_pkg::t_cnt r_ld_s, r_ld_i, r_ld_r;
    sirrk4_pkg::t_acc r_acc_k, r_acc_l, r_acc_m;
    logic r_fin, r_sat;
    logic [PW-1:0] r_ma, r_mp;
    logic [BW-1:0] r_mb;
    logic [XW-1:0] r_dx, r_dq;
    logic [NW-1:0] r_rem, r_dd;
    logic [KW-1:0] r_cnt;
    logic r_run, r_div, r_wb;
    logic [sirrk4_pkg::OPW-1:0] r_op;
    logic [1:0] r_stage;
    logic r_ov, r_o_fin, r_o_sat;
    sirrk4_pkg::t_cnt r_o_s, r_o_i, r_o_r;
    logic [TW-1:0] r_o_t;

    function automatic logic [CW-1:0] mag_cnt(input sirrk4_pkg::t_cnt v);
        logic [CW-1:0] u;
        u = v;
        return v[CW-1] ? (~u + 1'b1) : u;
    endfunction

    function automatic logic [QW-1:0] mag_acc(input sirrk4_pkg::t_acc v);
        logic [QW-1:0] u;
        u = v;
        return v[QW-1] ? (~u + 1'b1) : u;
    endfunction

    function automatic sirrk4_pkg::t_wide to_wide(input logic neg, input logic [PW-1:0] m);
        sirrk4_pkg::t_wide w;
        w = sirrk4_pkg::t_wide'({2'b00, m});
        return neg ? -w : w;
    endfunction

    sirrk4_pkg::t_clip c_inf, c_rec, c_k, c_l, c_kt, c_ss, c_lt, c_ii, c_ft, c_fn;
    sirrk4_pkg::t_cnt w_fbase;
    logic w_fneg;
    logic [PW-1:0] w_mp_sh, w_q;
    logic [NW:0] w_rem2;
    logic w_qbit;
    logic [TW:0] w_time;
    logic w_two;
    sirrk4_pkg::t_acc w_kx, w_lx, w_mx;

    always_comb begin
        w_q = (r_op == sirrk4_pkg::OP_DIV_N) ? PW'(r_dq) : (r_mp >> sirrk4_pkg::RCP3_SH);
        w_mp_sh = (r_stage == 2'd2) ? (r_mp >> 8) : (r_mp >> 9);
        c_inf = sirrk4_pkg::sat_cnt(to_wide(r_ii[CW-1] ^ r_ss[CW-1], w_q));
        c_rec = sirrk4_pkg::sat_cnt(to_wide(r_ii[CW-1], r_mp >> 16));
        c_k = sirrk4_pkg::sat_cnt(-sirrk4_pkg::t_wide'(r_inf));
        c_l = sirrk4_pkg::sat_cnt(sirrk4_pkg::t_wide'(r_inf) - sirrk4_pkg::t_wide'(r_rec));
        c_kt = sirrk4_pkg::sat_cnt(to_wide(r_k[CW-1], w_mp_sh));
        c_ss = sirrk4_pkg::sat_cnt(sirrk4_pkg::t_wide'(r_s) + sirrk4_pkg::t_wide'(c_kt.v));
        c_lt = sirrk4_pkg::sat_cnt(to_wide(r_l[CW-1], w_mp_sh));
        c_ii = sirrk4_pkg::sat_cnt(sirrk4_pkg::t_wide'(r_i) + sirrk4_pkg::t_wide'(c_lt.v));
        case (r_op)
            sirrk4_pkg::OP_DIV_FK: begin
                w_fneg = r_acc_k[QW-1];
                w_fbase = r_s;
            end
            sirrk4_pkg::OP_DIV_FL: begin
                w_fneg = r_acc_l[QW-1];
                w_fbase = r_i;
            end
            default: begin
                w_fneg = r_acc_m[QW-1];
                w_fbase = r_r;
            end
        endcase
        c_ft = sirrk4_pkg::sat_cnt(to_wide(w_fneg, w_q));
        c_fn = sirrk4_pkg::sat_cnt(sirrk4_pkg::t_wide'(w_fbase)
                                   + sirrk4_pkg::t_wide'(c_ft.v));
        w_time = {1'b0, r_time} + (TW + 1)'(r_h);
        w_two = (r_stage == 2'd1) || (r_stage == 2'd2);
        w_kx = sirrk4_pkg::t_acc'(c_k.v) <<< w_two;
        w_lx = sirrk4_pkg::t_acc'(c_l.v) <<< w_two;
        w_mx = sirrk4_pkg::t_acc'(r_rec) <<< w_two;
        w_rem2 = {r_rem, r_dx[XW-1]};
        w_qbit = (w_rem2 >= {1'b0, r_dd});
    end

    assign o_sts.done = r_wb;
    assign o_sts.at_stop = (r_time >= r_stop);
    assign o_sts.out_free = !r_ov || !i_stall;

    assign o_valid = r_ov;
    assign o_susceptible = r_o_s;
    assign o_infected = r_o_i;
    assign o_recovered = r_o_r;
    assign o_elapsed_time = r_o_t;
    assign o_finished = r_o_fin;
    assign o_saturated = r_o_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta <= sirrk4_pkg::RST_INFECTION_RATE;
            r_gamma <= sirrk4_pkg::RST_RECOVERY_RATE;
            r_pop <= sirrk4_pkg::RST_TOTAL_POPULATION;
            r_h <= sirrk4_pkg::RST_STEP_SIZE;
            r_stop <= sirrk4_pkg::RST_STOP_TIME;
            r_s <= '0;
            r_i <= '0;
            r_r <= '0;
            r_time <= '0;
            r_run <= 1'b0;
            r_wb <= 1'b0;
            r_div <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    sirrk4_pkg::REG_INFECTION_RATE:   r_beta <= i_cfg_wdata[RW-1:0];
                    sirrk4_pkg::REG_RECOVERY_RATE:    r_gamma <= i_cfg_wdata[RW-1:0];
                    sirrk4_pkg::REG_TOTAL_POPULATION: r_pop <= i_cfg_wdata[NW-1:0];
                    sirrk4_pkg::REG_STEP_SIZE:        r_h <= i_cfg_wdata[RW-1:0];
                    sirrk4_pkg::REG_STOP_TIME:        r_stop <= i_cfg_wdata[TW-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.accept) begin
                r_ld_s <= i_load_susceptible;
                r_ld_i <= i_load_infected;
                r_ld_r <= i_load_recovered;
                r_ss <= r_s;
                r_ii <= r_i;
                r_fin <= 1'b0;
                r_sat <= 1'b0;
            end

            r_wb <= 1'b0;
            if (i_cmd.start) begin
                r_op <= i_cmd.op;
                r_stage <= i_cmd.stage;
                r_mp <= '0;
                r_rem <= '0;
                r_dq <= '0;
                r_run <= 1'b1;
                r_div <= 1'b0;
                r_cnt <= KW'(BW);
                case (i_cmd.op)
                    sirrk4_pkg::OP_MUL_AI: begin
                        r_ma <= PW'(mag_cnt(r_ii));
                        r_mb <= BW'(r_beta);
                    end
                    sirrk4_pkg::OP_MUL_AS: begin
                        r_ma <= PW'(r_mp[AW-1:0]);
                        r_mb <= BW'(mag_cnt(r_ss));
                    end
                    sirrk4_pkg::OP_MUL_GI: begin
                        r_ma <= PW'(mag_cnt(r_ii));
                        r_mb <= BW'(r_gamma);
                    end
                    sirrk4_pkg::OP_MUL_KH: begin
                        r_ma <= PW'(mag_cnt(r_k));
                        r_mb <= BW'(r_h);
                    end
                    sirrk4_pkg::OP_MUL_LH: begin
                        r_ma <= PW'(mag_cnt(r_l));
                        r_mb <= BW'(r_h);
                    end
                    sirrk4_pkg::OP_MUL_FK: begin
                        r_ma <= PW'(mag_acc(r_acc_k));
                        r_mb <= BW'(r_h);
                    end
                    sirrk4_pkg::OP_MUL_FL: begin
                        r_ma <= PW'(mag_acc(r_acc_l));
                        r_mb <= BW'(r_h);
                    end
                    sirrk4_pkg::OP_MUL_FM: begin
                        r_ma <= PW'(mag_acc(r_acc_m));
                        r_mb <= BW'(r_h);
                    end
                    sirrk4_pkg::OP_DIV_N: begin
                        r_div <= 1'b1;
                        r_cnt <= KW'(XW);
                        r_dx <= XW'(r_mp >> SH);
                        r_dd <= (r_pop == '0) ? NW'(1) : r_pop;
                    end
                    sirrk4_pkg::OP_DIV_FK, sirrk4_pkg::OP_DIV_FL,
                    sirrk4_pkg::OP_DIV_FM: begin
                        r_ma <= r_mp >> 9;
                        r_mb <= sirrk4_pkg::RCP3;
                    end
                    default: begin
                        r_run <= 1'b0;
                        r_wb <= 1'b1;
                    end
                endcase
            end else if (r_run) begin
                r_cnt <= r_cnt - KW'(1);
                if (r_cnt == KW'(1)) begin
                    r_run <= 1'b0;
                    r_wb <= 1'b1;
                end
                if (r_div) begin
                    r_dx <= r_dx << 1;
                    r_dq <= {r_dq[XW-2:0], w_qbit};
                    r_rem <= w_qbit ? NW'(w_rem2 - {1'b0, r_dd}) : w_rem2[NW-1:0];
                end else begin
                    if (r_mb[0]) begin
                        r_mp <= r_mp + r_ma;
                    end
                    r_ma <= r_ma << 1;
                    r_mb <= r_mb >> 1;
                end
            end

            if (r_wb) begin
                case (r_op)
                    sirrk4_pkg::OP_LOAD: begin
                        r_s <= r_ld_s;
                        r_i <= r_ld_i;
                        r_r <= r_ld_r;
                        r_time <= '0;
                    end
                    sirrk4_pkg::OP_HOLD: r_fin <= 1'b1;
                    sirrk4_pkg::OP_DIV_N: begin
                        r_inf <= c_inf.v;
                        r_sat <= r_sat | c_inf.sat;
                    end
                    sirrk4_pkg::OP_MUL_GI: begin
                        r_rec <= c_rec.v;
                        r_sat <= r_sat | c_rec.sat;
                    end
                    sirrk4_pkg::OP_DERIV: begin
                        r_k <= c_k.v;
                        r_l <= c_l.v;
                        r_sat <= r_sat | c_k.sat | c_l.sat;
                        r_acc_k <= ((r_stage == 2'd0) ? '0 : r_acc_k) + w_kx;
                        r_acc_l <= ((r_stage == 2'd0) ? '0 : r_acc_l) + w_lx;
                        r_acc_m <= ((r_stage == 2'd0) ? '0 : r_acc_m) + w_mx;
                    end
                    sirrk4_pkg::OP_MUL_KH: begin
                        r_ss <= c_ss.v;
                        r_sat <= r_sat | c_kt.sat | c_ss.sat;
                    end
                    sirrk4_pkg::OP_MUL_LH: begin
                        r_ii <= c_ii.v;
                        r_sat <= r_sat | c_lt.sat | c_ii.sat;
                    end
                    sirrk4_pkg::OP_DIV_FK: begin
                        r_s <= c_fn.v;
                        r_sat <= r_sat | c_ft.sat | c_fn.sat;
                    end
                    sirrk4_pkg::OP_DIV_FL: begin
                        r_i <= c_fn.v;
                        r_sat <= r_sat | c_ft.sat | c_fn.sat;
                    end
                    sirrk4_pkg::OP_DIV_FM: begin
                        r_r <= c_fn.v;
                        r_sat <= r_sat | c_ft.sat | c_fn.sat;
                    end
                    sirrk4_pkg::OP_TIME: begin
                        if (w_time[TW]) begin
                            r_time <= '1;
                            r_sat <= 1'b1;
                        end else begin
                            r_time <= w_time[TW-1:0];
                        end
                    end
                    default: ;
                endcase
            end

            if (i_cmd.publish) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_o_s <= r_s;
            r_o_i <= r_i;
            r_o_r <= r_r;
            r_o_t <= r_time;
            r_o_fin <= r_fin;
            r_o_sat <= r_sat;
        end
    end

endmodule

@@ sv/sir_epidemic_rk4_step_unit.sv @@
`timescale 1ns / 1ps
// Load and finished items go straight from start to write-back and then to the output register.
// Step items: computed with one shift-add multiplier (24 uses) and one restoring divider by N
// (one bit a cycle, 4 uses). One item in flight; the next input transaction is taken the
// cycle after the result is registered. Synchronous active-low reset: rates, population,
// step size, stop time to defaults, counts and time to zero, output empty.
module sir_epidemic_rk4_step_unit #(
    parameter int P_VALUE_FRAC_BITS = sirrk4_pkg::DEF_VALUE_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [sirrk4_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sirrk4_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_cmd,
    input  logic signed [sirrk4_pkg::CW-1:0]    i_load_susceptible,
    input  logic signed [sirrk4_pkg::CW-1:0]    i_load_infected,
    input  logic signed [sirrk4_pkg::CW-1:0]    i_load_recovered,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [sirrk4_pkg::CW-1:0]    o_susceptible,
    output logic signed [sirrk4_pkg::CW-1:0]    o_infected,
    output logic signed [sirrk4_pkg::CW-1:0]    o_recovered,
    output logic [sirrk4_pkg::TW-1:0]           o_elapsed_time,
    output logic                                o_finished,
    output logic                                o_saturated
);

    sirrk4_pkg::t_cmd w_cmd;
    sirrk4_pkg::t_sts w_sts;

    sirrk4_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_cmd   (i_cmd),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    sirrk4_dp #(
        .P_VALUE_FRAC_BITS (P_VALUE_FRAC_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_load_susceptible (i_load_susceptible),
        .i_load_infected    (i_load_infected),
        .i_load_recovered   (i_load_recovered),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_susceptible      (o_susceptible),
        .o_infected         (o_infected),
        .o_recovered        (o_recovered),
        .o_elapsed_time     (o_elapsed_time),
        .o_finished         (o_finished),
        .o_saturated        (o_saturated)
    );

endmodule

@@ tb/tb_sir_epidemic_rk4_step_unit.sv @@
`timescale 1ns / 1ps
module tb_sir_epidemic_rk4_step_unit;

    localparam int VFB = sirrk4_pkg::DEF_VALUE_FRAC_BITS;
    localparam int CW = sirrk4_pkg::CW;
    localparam int TW = sirrk4_pkg::TW;
    localparam int CFG_IDX_W = sirrk4_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = sirrk4_pkg::CFG_DATA_W;
    localparam longint CNT_HI = 64'sd1099511627775;
    localparam longint CNT_LO = -CNT_HI - 1;
    localparam longint ONE = 64'sd1 << VFB;

    typedef struct {
        logic signed [CW-1:0] s;
        logic signed [CW-1:0] i;
        logic signed [CW-1:0] r;
        logic [TW-1:0]        t;
        logic                 fin;
        logic                 sat;
    } t_sir_out;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_cmd = 1'b0;
    logic signed [CW-1:0]  i_load_susceptible = '0;
    logic signed [CW-1:0]  i_load_infected = '0;
    logic signed [CW-1:0]  i_load_recovered = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic signed [CW-1:0]  o_susceptible;
    logic signed [CW-1:0]  o_infected;
    logic signed [CW-1:0]  o_recovered;
    logic [TW-1:0]         o_elapsed_time;
    logic                  o_finished;
    logic                  o_saturated;

    sir_epidemic_rk4_step_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #100_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    longint unsigned m_beta = sirrk4_pkg::RST_INFECTION_RATE;
    longint unsigned m_gamma = sirrk4_pkg::RST_RECOVERY_RATE;
    longint unsigned m_pop = sirrk4_pkg::RST_TOTAL_POPULATION;
    longint unsigned m_h = sirrk4_pkg::RST_STEP_SIZE;
    longint unsigned m_stop = sirrk4_pkg::RST_STOP_TIME;
    longint m_s = 0, m_i = 0, m_r = 0;
    longint unsigned m_t = 0;
    logic clipped;

    t_sir_out pending[$];
    int errors = 0;
    bit quiet = 1'b0;

    function automatic longint clamp(longint v);
        if (v > CNT_HI) begin
            clipped = 1'b1;
            return CNT_HI;
        end
        if (v < CNT_LO) begin
            clipped = 1'b1;
            return CNT_LO;
        end
        return v;
    endfunction

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint scale(longint v, longint unsigned mult, longint unsigned div);
        longint unsigned m;
        m = mag(v) * mult / div;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint infection(longint inf_i, longint inf_s);
        logic [127:0] a, p, q;
        longint unsigned n;
        longint m;
        n = (m_pop == 0) ? 1 : m_pop;
        a = 128'(mag(inf_i)) * 128'(m_beta);
        p = a * 128'(mag(inf_s));
        q = (p / 128'(n)) >> (VFB + 16);
        if (q > (128'd1 << 41)) q = 128'd1 << 41;
        m = longint'(q[63:0]);
        return clamp(((inf_i < 0) != (inf_s < 0)) ? -m : m);
    endfunction

    task automatic sir_rates(input longint s, input longint i,
                             output longint ds, output longint di, output longint dr);
        longint inf, rec;
        inf = infection(i, s);
        rec = clamp(scale(i, m_gamma, 65536));
        ds = clamp(-inf);
        di = clamp(inf - rec);
        dr = rec;
    endtask

    task automatic predict_sir(input logic cmd, input longint ls, input longint li,
                               input longint lr);
        t_sir_out e;
        longint k1, k2, k3, k4, l1, l2, l3, l4, n1, n2, n3, n4, ss, ii;
        clipped = 1'b0;
        e.fin = 1'b0;
        if (!cmd) begin
            m_s = ls;
            m_i = li;
            m_r = lr;
            m_t = 0;
        end else if (m_t >= m_stop) begin
            e.fin = 1'b1;
        end else begin
            sir_rates(m_s, m_i, k1, l1, n1);
            ss = clamp(m_s + clamp(scale(k1, m_h, 512)));
            ii = clamp(m_i + clamp(scale(l1, m_h, 512)));
            sir_rates(ss, ii, k2, l2, n2);
            ss = clamp(m_s + clamp(scale(k2, m_h, 512)));
            ii = clamp(m_i + clamp(scale(l2, m_h, 512)));
            sir_rates(ss, ii, k3, l3, n3);
            ss = clamp(m_s + clamp(scale(k3, m_h, 256)));
            ii = clamp(m_i + clamp(scale(l3, m_h, 256)));
            sir_rates(ss, ii, k4, l4, n4);
            m_s = clamp(m_s + clamp(scale(k1 + 2 * k2 + 2 * k3 + k4, m_h, 1536)));
            m_i = clamp(m_i + clamp(scale(l1 + 2 * l2 + 2 * l3 + l4, m_h, 1536)));
            m_r = clamp(m_r + clamp(scale(n1 + 2 * n2 + 2 * n3 + n4, m_h, 1536)));
            m_t = m_t + m_h;
            if (m_t > 64'hFFFF_FFFF) begin
                m_t = 64'hFFFF_FFFF;
                clipped = 1'b1;
            end
        end
        e.s = m_s[CW-1:0];
        e.i = m_i[CW-1:0];
        e.r = m_r[CW-1:0];
        e.t = m_t[TW-1:0];
        e.sat = clipped;
        pending.push_back(e);
    endtask

    function automatic int idle_len();
        if (quiet || $urandom_range(0, 3) != 0) return 0;
        return $urandom_range(1, 7);
    endfunction

    task automatic send_item(input logic cmd, input logic signed [CW-1:0] ls,
                             input logic signed [CW-1:0] li, input logic signed [CW-1:0] lr);
        int n;
        n = idle_len();
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_load_susceptible <= ls;
        i_load_infected <= li;
        i_load_recovered <= lr;
        do @(posedge i_clk); while (o_stall);
        predict_sir(cmd, longint'(ls), longint'(li), longint'(lr));
    endtask

    task automatic step_sir();
        send_item(1'b1, 41'(longint'($urandom)), 41'(longint'($urandom)), 41'(longint'($urandom)));
    endtask

    task automatic load_sir(input longint s, input longint i, input longint r);
        send_item(1'b0, s[CW-1:0], i[CW-1:0], r[CW-1:0]);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            sirrk4_pkg::REG_INFECTION_RATE: m_beta = val & 64'hFFFF;
            sirrk4_pkg::REG_RECOVERY_RATE: m_gamma = val & 64'hFFFF;
            sirrk4_pkg::REG_TOTAL_POPULATION: m_pop = val & 64'h1F_FFFF;
            sirrk4_pkg::REG_STEP_SIZE: m_h = val & 64'hFFFF;
            sirrk4_pkg::REG_STOP_TIME: m_stop = val & 64'hFFFF_FFFF;
            default: ;
        endcase
    endtask

    function automatic logic signed [CW-1:0] rand41();
        logic [63:0] x;
        x = {$urandom, $urandom};
        return x[CW-1:0];
    endfunction

    always @(posedge i_clk) begin
        int cnt;
        if (quiet || !i_rst_n) begin
            i_stall <= 1'b0;
            cnt = 0;
        end else if (cnt > 0) begin
            cnt = cnt - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            i_stall <= 1'b1;
            cnt = $urandom_range(0, 6);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_sir_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending.size() == 0) begin
                $display("%0t: unexpected transaction s=%h", $time, o_susceptible);
                errors++;
            end else begin
                e = pending.pop_front();
                if (o_susceptible !== e.s) begin
                    $display("%0t: susceptible exp %h got %h", $time, e.s, o_susceptible);
                    errors++;
                end
                if (o_infected !== e.i) begin
                    $display("%0t: infected exp %h got %h", $time, e.i, o_infected);
                    errors++;
                end
                if (o_recovered !== e.r) begin
                    $display("%0t: recovered exp %h got %h", $time, e.r, o_recovered);
                    errors++;
                end
                if (o_elapsed_time !== e.t) begin
                    $display("%0t: elapsed_time exp %h got %h", $time, e.t, o_elapsed_time);
                    errors++;
                end
                if (o_finished !== e.fin) begin
                    $display("%0t: finished exp %b got %b", $time, e.fin, o_finished);
                    errors++;
                end
                if (o_saturated !== e.sat) begin
                    $display("%0t: saturated exp %b got %b", $time, e.sat, o_saturated);
                    errors++;
                end
            end
        end
    end

    task automatic test_defaults();
        load_sir(990 * ONE, 10 * ONE, 0);
        repeat (3) step_sir();
    endtask

    task automatic test_load_extremes();
        load_sir(CNT_HI, CNT_HI, CNT_HI);
        step_sir();
        load_sir(CNT_LO, CNT_LO, CNT_LO);
        step_sir();
        load_sir(CNT_LO, CNT_HI, 0);
        step_sir();
        load_sir(0, 0, 0);
        step_sir();
    endtask

    task automatic test_finished();
        cfg_write(sirrk4_pkg::REG_STOP_TIME, 0);
        step_sir();
        load_sir(500 * ONE, 50 * ONE, 400 * ONE);
        step_sir();
        cfg_write(sirrk4_pkg::REG_STOP_TIME, 64'hFFFF_FFFF);
        step_sir();
    endtask

    task automatic test_rate_extremes();
        cfg_write(sirrk4_pkg::REG_INFECTION_RATE, 65535);
        cfg_write(sirrk4_pkg::REG_RECOVERY_RATE, 65535);
        cfg_write(sirrk4_pkg::REG_TOTAL_POPULATION, 1);
        cfg_write(sirrk4_pkg::REG_STEP_SIZE, 65535);
        load_sir(550 * ONE, 500 * ONE, 0);
        step_sir();
        step_sir();
        cfg_write(sirrk4_pkg::REG_TOTAL_POPULATION, 0);
        load_sir(1000 * ONE, 5 * ONE, 0);
        step_sir();
        cfg_write(sirrk4_pkg::REG_TOTAL_POPULATION, 1048576);
        step_sir();
        cfg_write(sirrk4_pkg::REG_STEP_SIZE, 0);
        step_sir();
        cfg_write(sirrk4_pkg::REG_STEP_SIZE, 1);
        cfg_write(sirrk4_pkg::REG_INFECTION_RATE, 0);
        cfg_write(sirrk4_pkg::REG_RECOVERY_RATE, 0);
        step_sir();
    endtask

    function automatic longint unsigned pick(longint unsigned lo, longint unsigned hi);
        int c;
        c = $urandom_range(0, 5);
        if (c == 0) return lo;
        if (c == 1) return hi;
        return lo + (({$urandom, $urandom}) % (hi - lo + 1));
    endfunction

    task automatic test_random();
        longint unsigned n;
        for (int ph = 0; ph < 22; ph++) begin
            if (ph == 19) begin
                drain();
                quiet = 1'b1;
            end
            cfg_write(sirrk4_pkg::REG_INFECTION_RATE, pick(0, 65535));
            cfg_write(sirrk4_pkg::REG_RECOVERY_RATE, pick(0, 65535));
            cfg_write(sirrk4_pkg::REG_TOTAL_POPULATION, pick(0, 1048576));
            cfg_write(sirrk4_pkg::REG_STEP_SIZE, pick(0, 65535));
            if ($urandom_range(0, 3) == 0)
                cfg_write(sirrk4_pkg::REG_STOP_TIME, $urandom_range(0, 1_000_000));
            else
                cfg_write(sirrk4_pkg::REG_STOP_TIME, pick(0, 64'hFFFF_FFFF));
            n = (m_pop == 0) ? 1 : m_pop;
            for (int k = 0; k < 50; k++) begin
                if (k == 0 || $urandom_range(0, 9) == 0) begin
                    if ($urandom_range(0, 3) == 0)
                        send_item(1'b0, rand41(), rand41(), rand41());
                    else
                        load_sir(longint'($urandom_range(0, 32'(n))) * ONE,
                                 longint'($urandom % 32'(n < 4096 ? n : 4096)) * ONE
                                     + longint'($urandom_range(0, 32'(ONE))),
                                 longint'($urandom_range(0, 32'(n))) * ONE);
                end else begin
                    step_sir();
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_load_extremes();
        test_finished();
        test_rate_extremes();
        test_random();
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
